@@ hdl/uuidp_pkg.sv @@
// ----------------------------------------------------------------------------
// uuidp_pkg
// Shared constants, queue word type and character decode for the UUID text
// parser.
// ----------------------------------------------------------------------------
package uuidp_pkg;

  localparam int unsigned TextLen     = 36;
  localparam int unsigned VersionPos  = 14;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned PosW        = 6;

  localparam logic [7:0] CharHyphen   = 8'h2d;
  localparam logic [7:0] CharVersion  = 8'h34;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [7:0] CharNine     = 8'h39;
  localparam logic [7:0] CharLowA     = 8'h61;
  localparam logic [7:0] CharLowF     = 8'h66;
  localparam logic [7:0] CharUpA      = 8'h41;
  localparam logic [7:0] CharUpF      = 8'h46;

  // one classified character, front to back
  typedef struct packed {
    logic       last;
    logic       shift;
    logic       bad;
    logic       len_ok;
    logic [3:0] nib;
  } op_t;

  // decoded hex digit: bad set when the byte is not a hex digit
  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    logic [7:0] d;
    r = '{bad: 1'b1, nib: 4'd0};
    d = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
      r = '{bad: 1'b0, nib: d[3:0]};
    end else if (c >= CharLowA && c <= CharLowF) begin
      d = c - CharLowA + 8'd10;
      r = '{bad: 1'b0, nib: d[3:0]};
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = c - CharUpA + 8'd10;
      r = '{bad: 1'b0, nib: d[3:0]};
    end
    return r;
  endfunction

endpackage

@@ hdl/uuidp_front.sv @@
// ----------------------------------------------------------------------------
// uuidp_front
// Accepts characters, tracks the text position and classifies each word.
// ----------------------------------------------------------------------------
module uuidp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  input  logic                 q_full,
  output logic                 push,
  output uuidp_pkg::op_t       op
);

  logic [uuidp_pkg::PosW-1:0] pos;
  logic [uuidp_pkg::PosW-1:0] pos_next;
  uuidp_pkg::hex_t            hx;
  logic                       hyphen_pos;
  logic                       over;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign hx         = uuidp_pkg::hex_decode(char_code);
  assign over       = pos >= uuidp_pkg::PosW'(uuidp_pkg::TextLen);
  assign hyphen_pos = (pos == 6'd8) || (pos == 6'd13) || (pos == 6'd18) || (pos == 6'd23);

  always_comb begin
    op.last   = last_char;
    op.len_ok = pos == uuidp_pkg::PosW'(uuidp_pkg::TextLen - 1);
    op.nib    = hx.nib;
    op.shift  = 1'b0;
    op.bad    = 1'b0;
    if (over) begin
      op.bad = 1'b1;
    end else if (hyphen_pos) begin
      op.bad = char_code != uuidp_pkg::CharHyphen;
    end else begin
      op.shift = 1'b1;
      op.bad   = hx.bad ||
                 (pos == uuidp_pkg::PosW'(uuidp_pkg::VersionPos) &&
                  char_code != uuidp_pkg::CharVersion);
    end
  end

  always_comb begin
    pos_next = pos;
    if (push) begin
      if (last_char) begin
        pos_next = '0;
      end else if (!over) begin
        pos_next = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // position saturates at the text length
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    pos <= uuidp_pkg::PosW'(uuidp_pkg::TextLen))
    else $error("position past saturation");

endmodule

@@ hdl/uuidp_fifo.sv @@
// ----------------------------------------------------------------------------
// uuidp_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module uuidp_fifo #(
  parameter int unsigned DEPTH = uuidp_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  uuidp_pkg::op_t push_op,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output uuidp_pkg::op_t head_op
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  uuidp_pkg::op_t  mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = count == CntW'(DEPTH);
  assign not_empty = count != '0;
  assign head_op   = mem[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

endmodule

@@ hdl/uuidp_back.sv @@
// ----------------------------------------------------------------------------
// uuidp_back
// Shifts digits into the 128-bit value, keeps the sticky error and holds the
// result register.
// ----------------------------------------------------------------------------
module uuidp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           not_empty,
  input  uuidp_pkg::op_t head_op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    uuid_high,
  output logic [63:0]    uuid_low,
  output logic           is_valid
);

  logic [63:0]  hi;
  logic [63:0]  lo;
  logic         err;
  logic [127:0] val_next;
  logic         err_next;
  logic         ok;

  // a last word needs the result register free or draining this cycle
  assign pop = not_empty && (!head_op.last || !out_valid || !out_stall);

  always_comb begin
    val_next = {hi, lo};
    if (head_op.shift) begin
      val_next = {hi[59:0], lo, head_op.nib};
    end
    err_next = err || head_op.bad;
    ok       = !err_next && head_op.len_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi        <= '0;
      lo        <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head_op.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head_op.last) begin
          hi        <= '0;
          lo        <= '0;
          err       <= 1'b0;
          uuid_high <= ok ? val_next[127:64] : '0;
          uuid_low  <= ok ? val_next[63:0] : '0;
          is_valid  <= ok;
        end else begin
          hi  <= val_next[127:64];
          lo  <= val_next[63:0];
          err <= err_next;
        end
      end
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_valid |-> uuid_high == '0 && uuid_low == '0)
    else $error("invalid result carries data");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && head_op.last |=> !err && hi == '0 && lo == '0)
    else $error("state not cleared after last word");

endmodule

@@ hdl/uuid_text_parser_core.sv @@
// ----------------------------------------------------------------------------
// uuid_text_parser_core
// Version 4 UUID text checker and decoder, one character per word.
// ----------------------------------------------------------------------------
// Input channel: char_code with last_char marking the final character of a
// text. Output channel: one word per text, given on the word with last_char:
// uuid_high, uuid_low and is_valid (halves are zero when the text is bad).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low.
// Throughput: one character per cycle while out_stall is low, texts back to back.
// Result path: the last character is queued when accepted and moves to the
// result register, raising out_valid, when the back stage pops it.
// The front stage counts positions and classifies characters; the back
// stage shifts nibbles and keeps the error flag; a QUEUE_DEPTH-entry queue
// sits between them. While the receiver stalls, the result register holds
// and non-final characters still drain; once a final character waits behind
// the held result the queue fills and in_stall rises when QUEUE_DEPTH words,
// the waiting final character among them, are queued.
// Reset clears the position, error flag, value, queue and out_valid, not the result data or is_valid.
// ----------------------------------------------------------------------------
module uuid_text_parser_core #(
  parameter int unsigned QUEUE_DEPTH = uuidp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] uuid_high,
  output logic [63:0] uuid_low,
  output logic        is_valid
);

  uuidp_pkg::op_t push_op;
  uuidp_pkg::op_t head_op;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;

  uuidp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .q_full    (q_full),
    .push      (push),
    .op        (push_op)
  );

  uuidp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head_op   (head_op)
  );

  uuidp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .uuid_high (uuid_high),
    .uuid_low  (uuid_low),
    .is_valid  (is_valid)
  );

endmodule
